@@ design/mprs_pkg.sv @@
// Shared types, constants and helper functions of the multicast probe rate scheduler.
package mprs_pkg;

    localparam int RATE_SLOTS = 4;
    localparam int SLOT_W     = $clog2(RATE_SLOTS);
    localparam int ID_WRAP    = 5000;
    localparam int ID_W       = $clog2(ID_WRAP + 1);
    localparam int DRAW_LIMIT = 64;
    localparam int DRAW_W     = $clog2(DRAW_LIMIT);
    localparam int RATE_CODES = 16;

    localparam logic [31:0] LFSR_TAPS    = 32'hA300_0000;
    localparam logic [7:0]  UDP_PROTO    = 8'd17;
    localparam logic [31:0] RST_GROUP    = 32'hE000_4343;
    localparam logic [7:0]  RST_MAIN     = 8'd70;
    localparam logic [7:0]  RST_PROBE    = 8'd10;
    localparam logic [7:0]  RST_INTERVAL = 8'd100;
    localparam logic [31:0] RST_SEED     = 32'd1;

    // invalid rate codes form one block
    localparam logic [3:0] RATE_INV_LO = 4'd8;
    localparam logic [3:0] RATE_INV_HI = 4'd11;
    localparam logic [3:0] RATE_LOWEST = 4'd0;
    localparam logic [3:0] RATE_HIGHEST = 4'd15;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED     = 3'd4;

    typedef logic [3:0] t_rate;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] dest_address;
        logic        feedback_arrived;
        logic [3:0]  default_rate;
    } t_in_item;

    typedef struct packed {
        logic        selected;
        logic [3:0]  rate_index;
        logic [12:0] packet_id;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_REBUILD,
        S_ADD,
        S_ADD_FB,
        S_PICK,
        S_SLOT,
        S_SLOT_FB,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic rebuild;
        logic add_draw;
        logic add_fallback;
        logic pick_default;
        logic slot_draw;
        logic slot_fallback;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic feedback;
        logic pick_direct;
        logic add_ok;
        logic add_last;
        logic slot_ok;
    } t_stat;

    function automatic logic f_invalid(input t_rate r);
        return (r >= RATE_INV_LO) && (r <= RATE_INV_HI);
    endfunction

    // high/low alternation applies away from the ends of the rate range
    function automatic logic f_constrained(input t_rate d);
        return !(d == 4'd0 || d == 4'd1 || d == 4'd14 || d == 4'd15);
    endfunction

    // next valid rate above d, saturating at the top code
    function automatic t_rate f_rate_above(input t_rate d);
        logic [4:0] r;
        r = {1'b0, d} + 5'd1;
        for (int k = 0; k < 4; k++) begin
            if (r[4] == 1'b0 && f_invalid(r[3:0])) begin
                r = r + 5'd1;
            end
        end
        return r[4] ? RATE_HIGHEST : r[3:0];
    endfunction

    // next valid rate below d
    function automatic t_rate f_rate_below(input t_rate d);
        t_rate r;
        r = d - 4'd1;
        for (int k = 0; k < 4; k++) begin
            if (f_invalid(r)) begin
                r = r - 4'd1;
            end
        end
        return r;
    endfunction

    // Galois step: shift right, fold taps when a one drops out
    function automatic logic [31:0] f_lfsr_step(input logic [31:0] x);
        return {1'b0, x[31:1]} ^ (x[0] ? LFSR_TAPS : 32'd0);
    endfunction

endpackage

@@ design/mprs_ctrl.sv @@
// Controller state machine of the multicast probe rate scheduler.
module mprs_ctrl import mprs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic [DRAW_W-1:0] r_draws, n_draws;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic draw_miss;
    logic draw_last;

    assign out_free  = !r_out_valid || i_out_ready;
    assign draw_last = (r_draws == DRAW_W'(DRAW_LIMIT - 1));
    assign draw_miss = (r_state == S_ADD  && !i_stat.add_ok) ||
                       (r_state == S_SLOT && !i_stat.slot_ok);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.match) begin
                    n_state = S_EMIT;
                end else if (i_stat.feedback) begin
                    n_state = S_REBUILD;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_REBUILD: n_state = S_ADD;
            S_ADD: begin
                if (i_stat.add_ok) begin
                    n_state = i_stat.add_last ? S_PICK : S_ADD;
                end else if (draw_last) begin
                    n_state = S_ADD_FB;
                end
            end
            S_ADD_FB: n_state = i_stat.add_last ? S_PICK : S_ADD;
            S_PICK:   n_state = i_stat.pick_direct ? S_EMIT : S_SLOT;
            S_SLOT: begin
                if (i_stat.slot_ok) begin
                    n_state = S_EMIT;
                end else if (draw_last) begin
                    n_state = S_SLOT_FB;
                end
            end
            S_SLOT_FB: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            S_CHECK:   ;
            S_REBUILD: o_cmd.rebuild       = 1'b1;
            S_ADD:     o_cmd.add_draw      = 1'b1;
            S_ADD_FB:  o_cmd.add_fallback  = 1'b1;
            S_PICK:    o_cmd.pick_default  = i_stat.pick_direct;
            S_SLOT:    o_cmd.slot_draw     = 1'b1;
            S_SLOT_FB: o_cmd.slot_fallback = 1'b1;
            S_EMIT:    o_cmd.emit          = out_free;
            default:   ;
        endcase
    end

    // draw counter runs only across misses of one retry loop
    always_comb begin
        n_draws = draw_miss ? r_draws + 1'b1 : '0;
    end

    always_comb begin
        n_out_valid = o_cmd.emit ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_draws     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_draws     <= n_draws;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result valid rose outside emit");

    a_add_fb_after_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_FB) |-> ($past(r_state) == S_ADD &&
                                   $past(r_draws) == DRAW_W'(DRAW_LIMIT - 1)))
        else $error("rate fallback before draw limit");

    a_slot_fb_after_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOT_FB) |-> ($past(r_state) == S_SLOT &&
                                    $past(r_draws) == DRAW_W'(DRAW_LIMIT - 1)))
        else $error("slot fallback before draw limit");

endmodule

@@ design/mprs_dp.sv @@
// Datapath of the multicast probe rate scheduler: config, rate table, budgets, LFSR, result.
module mprs_dp import mprs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  t_in_item             i_in_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_out_item            o_out_item
);

    t_in_item          r_item;
    logic [31:0]       r_group;
    logic [7:0]        r_main_budget;
    logic [7:0]        r_probe_budget;
    logic [7:0]        r_interval;
    logic [31:0]       r_lfsr;
    t_rate             r_table  [RATE_SLOTS];
    logic [7:0]        r_budget [RATE_SLOTS];
    logic [7:0]        r_sent;
    logic [ID_W-1:0]   r_next_id;
    logic              r_pick_high;
    logic [SLOT_W-1:0] r_slot;
    t_rate             r_rate;
    t_out_item         r_out;

    logic [31:0]           lfsr_nxt;
    t_rate                 draw_rate;
    logic [SLOT_W-1:0]     draw_slot;
    logic                  constr;
    logic                  end_rate;
    logic [RATE_CODES-1:0] in_lower;
    logic [RATE_CODES-1:0] side_ok;
    logic [RATE_CODES-1:0] invalid;
    logic [RATE_CODES-1:0] fb_mask1;
    logic [RATE_CODES-1:0] fb_mask2;
    logic                  fb_use1;
    t_rate                 fb_rate;
    logic                  add_ok;
    logic                  add_toggle;
    logic [RATE_SLOTS-1:0] budget_nz;
    logic                  any_budget;
    logic [SLOT_W-1:0]     fb_slot;
    logic [SLOT_W-1:0]     sel_slot;
    logic                  match;

    assign lfsr_nxt  = f_lfsr_step(r_lfsr);
    assign draw_rate = lfsr_nxt[3:0];
    assign draw_slot = lfsr_nxt[SLOT_W-1:0];
    assign constr    = f_constrained(r_item.default_rate);
    assign end_rate  = (r_item.default_rate == RATE_LOWEST) ||
                       (r_item.default_rate == RATE_HIGHEST);
    assign match     = (r_item.protocol == UDP_PROTO) && (r_item.dest_address == r_group);

    // per-code acceptability against the slots already filled
    always_comb begin
        for (int v = 0; v < RATE_CODES; v++) begin
            in_lower[v] = 1'b0;
            for (int i = 0; i < RATE_SLOTS; i++) begin
                if ((SLOT_W'(i) < r_slot) && (r_table[i] == 4'(v))) begin
                    in_lower[v] = 1'b1;
                end
            end
            side_ok[v] = r_pick_high ? (4'(v) >= r_table[1]) : (4'(v) <= r_table[1]);
            invalid[v] = f_invalid(4'(v));
        end
    end

    assign add_toggle = !in_lower[draw_rate] && constr && side_ok[draw_rate];
    assign add_ok     = !in_lower[draw_rate] && (!constr || side_ok[draw_rate]) &&
                        !invalid[draw_rate];

    assign fb_mask2 = ~in_lower & ~invalid;
    assign fb_mask1 = fb_mask2 & (constr ? side_ok : '1);
    assign fb_use1  = |fb_mask1;

    // lowest acceptable code; the side constraint is dropped when nothing meets it
    always_comb begin
        fb_rate = '0;
        for (int v = RATE_CODES - 1; v >= 0; v--) begin
            if (fb_use1 ? fb_mask1[v] : fb_mask2[v]) begin
                fb_rate = 4'(v);
            end
        end
    end

    always_comb begin
        fb_slot = '0;
        for (int i = RATE_SLOTS - 1; i >= 0; i--) begin
            budget_nz[i] = (r_budget[i] != 8'd0);
        end
        for (int i = RATE_SLOTS - 1; i >= 0; i--) begin
            if (budget_nz[i]) begin
                fb_slot = SLOT_W'(i);
            end
        end
    end

    assign any_budget = |budget_nz;
    assign sel_slot   = i_cmd.slot_draw ? draw_slot : fb_slot;

    always_comb begin
        o_stat.match       = match;
        o_stat.feedback    = r_item.feedback_arrived;
        o_stat.pick_direct = (r_sent >= r_interval) || !any_budget;
        o_stat.add_ok      = add_ok;
        o_stat.add_last    = (r_slot == SLOT_W'(RATE_SLOTS - 1));
        o_stat.slot_ok     = budget_nz[draw_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group        <= RST_GROUP;
            r_main_budget  <= RST_MAIN;
            r_probe_budget <= RST_PROBE;
            r_interval     <= RST_INTERVAL;
            r_lfsr         <= RST_SEED;
            r_sent         <= '0;
            r_next_id      <= '0;
            r_pick_high    <= 1'b1;
            for (int i = 0; i < RATE_SLOTS; i++) begin
                r_table[i]  <= '0;
                r_budget[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GROUP:    r_group        <= i_cfg_data;
                    CFG_MAIN:     r_main_budget  <= i_cfg_data[7:0];
                    CFG_PROBE:    r_probe_budget <= i_cfg_data[7:0];
                    CFG_INTERVAL: r_interval     <= i_cfg_data[7:0];
                    CFG_SEED:     r_lfsr <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                    default:      ;
                endcase
            end else if (i_cmd.add_draw || i_cmd.slot_draw) begin
                r_lfsr <= lfsr_nxt;
            end

            if (i_cmd.rebuild) begin
                for (int i = 0; i < RATE_SLOTS; i++) begin
                    r_table[i]  <= '0;
                    r_budget[i] <= (i == 0) ? r_main_budget : r_probe_budget;
                end
                r_table[0] <= r_item.default_rate;
                if (r_item.default_rate == RATE_LOWEST) begin
                    r_table[1] <= 4'd1;
                end else if (r_item.default_rate == RATE_HIGHEST) begin
                    r_table[1] <= 4'd14;
                end else begin
                    r_table[1] <= f_rate_above(r_item.default_rate);
                    r_table[2] <= f_rate_below(r_item.default_rate);
                end
                r_sent <= '0;
            end

            if (i_cmd.add_draw) begin
                if (add_toggle) begin
                    r_pick_high <= !r_pick_high;
                end
                if (add_ok) begin
                    r_table[r_slot] <= draw_rate;
                end
            end

            if (i_cmd.add_fallback) begin
                if (fb_use1 && constr) begin
                    r_pick_high <= !r_pick_high;
                end
                r_table[r_slot] <= fb_rate;
            end

            if ((i_cmd.slot_draw && budget_nz[draw_slot]) ||
                (i_cmd.slot_fallback && any_budget)) begin
                r_budget[sel_slot] <= r_budget[sel_slot] - 8'd1;
            end

            if (i_cmd.emit && match) begin
                r_next_id <= (r_next_id >= ID_W'(ID_WRAP)) ? '0 : r_next_id + 1'b1;
                if (r_sent != 8'hFF) begin
                    r_sent <= r_sent + 8'd1;
                end
            end
        end
    end

    // item latch, fill slot pointer and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_item <= i_in_item;
        end
        if (i_cmd.rebuild) begin
            r_slot <= end_rate ? SLOT_W'(2) : SLOT_W'(3);
        end else if ((i_cmd.add_draw && add_ok) || i_cmd.add_fallback) begin
            r_slot <= r_slot + 1'b1;
        end
        if (i_cmd.pick_default) begin
            r_rate <= r_table[0];
        end else if ((i_cmd.slot_draw && budget_nz[draw_slot]) || i_cmd.slot_fallback) begin
            r_rate <= r_table[sel_slot];
        end
        if (i_cmd.emit) begin
            if (match) begin
                r_out.selected   <= 1'b1;
                r_out.rate_index <= r_rate;
                r_out.packet_id  <= 13'(r_next_id);
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_out_item = r_out;

    a_slot_has_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.slot_draw || i_cmd.slot_fallback) |-> any_budget)
        else $error("slot draw with all budgets empty");

    a_id_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_next_id <= ID_W'(ID_WRAP)))
        else $error("packet id beyond wrap value");

endmodule

@@ design/multicast_probe_rate_scheduler.sv @@
// Top level of the multicast probe rate scheduler: controller plus datapath.
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  ---------------------------
//  in       in   i_in_valid / o_in_ready   i_in_item  (t_in_item)
//  out      out  o_out_valid / i_out_ready o_out_item (t_out_item)
//  cfg      in   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item in flight. After accept, check sends an unmatched item to emit and
// the output register; a matched one to pick, then, if needed, slot draws up
// to the draw limit, then a fallback, then emit. A rebuild, before pick, adds its
// state and such draws per random slot (one or two). Each draw steps the single
// shared LFSR once per cycle bar a config write. Ready returns with the result.
// Reset (synchronous, active low) restores register defaults and an LFSR of 1.
// A finished result sits in the output register while the next item is
// accepted; a stalled output holds the controller in its emit state.
// Config writes are always taken (o_cfg_ready high); index 4 reloads the LFSR.
module multicast_probe_rate_scheduler import mprs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // registers sit in the datapath, so a write needs no wait
    assign o_cfg_ready = 1'b1;

    mprs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mprs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

endmodule

@@ bench/rate_sched_checker.sv @@
// Checker for the multicast probe rate scheduler: mirrors its state and compares result items.
`timescale 1ns / 100ps
module rate_sched_checker import mprs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    // mirrored registers
    logic [31:0] group_r;
    logic [7:0]  main_r;
    logic [7:0]  probe_r;
    logic [7:0]  interval_r;

    // mirrored state
    t_rate       rate_tbl [RATE_SLOTS];
    logic [7:0]  budget [RATE_SLOTS];
    logic [7:0]  sent_cnt;
    int unsigned id_cnt;
    logic        go_high;
    logic [31:0] lfsr;

    t_out_item   due_tags [$];
    int          mismatches = 0;
    int          due_cnt = 0;

    assign o_errors  = mismatches;
    assign o_pending = due_cnt;

    function automatic logic [31:0] step_lfsr();
        logic drop;
        drop = lfsr[0];
        lfsr = lfsr >> 1;
        if (drop) begin
            lfsr = lfsr ^ LFSR_TAPS;
        end
        return lfsr;
    endfunction

    function automatic logic bad_rate(input t_rate r);
        return (r >= RATE_INV_LO) && (r <= RATE_INV_HI);
    endfunction

    function automatic logic taken_below(input t_rate r, input int slot);
        for (int i = 0; i < slot; i++) begin
            if (rate_tbl[i] == r) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic on_side(input t_rate r);
        return go_high ? (r >= rate_tbl[1]) : (r <= rate_tbl[1]);
    endfunction

    // random distinct rate for one slot, alternating sides when paired
    function automatic void fill_slot(input int slot, input logic paired);
        logic [31:0] d;
        t_rate       r;
        logic        placed;
        placed = 1'b0;
        for (int n = 0; n < DRAW_LIMIT && !placed; n++) begin
            d = step_lfsr();
            r = d[3:0];
            if (!taken_below(r, slot) && !(paired && !on_side(r))) begin
                // the side flips even when the rate then turns out invalid
                if (paired) begin
                    go_high = !go_high;
                end
                if (!bad_rate(r)) begin
                    rate_tbl[slot] = r;
                    placed = 1'b1;
                end
            end
        end
        // out of draws: smallest acceptable rate, then drop the side rule
        for (int k = 0; k < RATE_CODES && !placed; k++) begin
            r = t_rate'(k);
            if (!taken_below(r, slot) && !bad_rate(r) && (!paired || on_side(r))) begin
                if (paired) begin
                    go_high = !go_high;
                end
                rate_tbl[slot] = r;
                placed = 1'b1;
            end
        end
        for (int k = 0; k < RATE_CODES && !placed; k++) begin
            r = t_rate'(k);
            if (!taken_below(r, slot) && !bad_rate(r)) begin
                rate_tbl[slot] = r;
                placed = 1'b1;
            end
        end
    endfunction

    function automatic void rebuild_table(input t_rate def);
        logic  paired;
        t_rate r;
        int    k;
        paired = !(def == 4'd0 || def == 4'd1 || def == 4'd14 || def == 4'd15);
        budget[0] = main_r;
        for (int i = 1; i < RATE_SLOTS; i++) begin
            budget[i] = probe_r;
        end
        for (int i = 0; i < RATE_SLOTS; i++) begin
            rate_tbl[i] = '0;
        end
        sent_cnt = '0;
        rate_tbl[0] = def;
        if (def == RATE_LOWEST || def == RATE_HIGHEST) begin
            rate_tbl[1] = (def == RATE_LOWEST) ? 4'd1 : 4'd14;
            fill_slot(2, paired);
            fill_slot(3, paired);
        end else begin
            k = def + 1;
            while (k <= 15 && bad_rate(t_rate'(k))) begin
                k++;
            end
            rate_tbl[1] = (k <= 15) ? t_rate'(k) : RATE_HIGHEST;
            r = def - 4'd1;
            while (bad_rate(r)) begin
                r = r - 4'd1;
            end
            rate_tbl[2] = r;
            fill_slot(3, paired);
        end
    endfunction

    function automatic t_rate choose_rate();
        logic [31:0] d;
        logic [1:0]  s;
        logic        any;
        if (sent_cnt >= interval_r) begin
            return rate_tbl[0];
        end
        any = 1'b0;
        for (int i = 0; i < RATE_SLOTS; i++) begin
            if (budget[i] != 0) begin
                any = 1'b1;
            end
        end
        if (!any) begin
            return rate_tbl[0];
        end
        for (int n = 0; n < DRAW_LIMIT; n++) begin
            d = step_lfsr();
            s = d[1:0];
            if (budget[s] != 0) begin
                budget[s] = budget[s] - 8'd1;
                return rate_tbl[s];
            end
        end
        for (int i = 0; i < RATE_SLOTS; i++) begin
            if (budget[i] != 0) begin
                budget[i] = budget[i] - 8'd1;
                return rate_tbl[i];
            end
        end
        return rate_tbl[0];
    endfunction

    function automatic t_out_item schedule_packet(input t_in_item pkt);
        t_out_item tag;
        t_rate     r;
        tag = '0;
        if (pkt.protocol != UDP_PROTO || pkt.dest_address != group_r) begin
            return tag;
        end
        if (pkt.feedback_arrived) begin
            rebuild_table(pkt.default_rate);
        end
        r = choose_rate();
        tag.selected   = 1'b1;
        tag.rate_index = r;
        tag.packet_id  = id_cnt[12:0];
        id_cnt = (id_cnt >= ID_WRAP) ? 0 : id_cnt + 1;
        if (sent_cnt != 8'hFF) begin
            sent_cnt = sent_cnt + 8'd1;
        end
        return tag;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            group_r    = RST_GROUP;
            main_r     = RST_MAIN;
            probe_r    = RST_PROBE;
            interval_r = RST_INTERVAL;
            lfsr       = RST_SEED;
            for (int i = 0; i < RATE_SLOTS; i++) begin
                rate_tbl[i] = '0;
                budget[i]   = '0;
            end
            sent_cnt = '0;
            id_cnt   = 0;
            go_high  = 1'b1;
            due_tags.delete();
        end else begin
            // results first, so an item taken in this same cycle is not matched to them
            if (i_out_valid && i_out_ready) begin
                if (due_tags.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with none due: expected nothing, got %0d/%0d/%0d",
                             $time, i_out_item.selected, i_out_item.rate_index,
                             i_out_item.packet_id);
                end else begin
                    want = due_tags.pop_front();
                    check_field("selected", 32'(want.selected), 32'(i_out_item.selected));
                    check_field("rate_index", 32'(want.rate_index),
                                32'(i_out_item.rate_index));
                    check_field("packet_id", 32'(want.packet_id),
                                32'(i_out_item.packet_id));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GROUP:    group_r    = i_cfg_data;
                    CFG_MAIN:     main_r     = i_cfg_data[7:0];
                    CFG_PROBE:    probe_r    = i_cfg_data[7:0];
                    CFG_INTERVAL: interval_r = i_cfg_data[7:0];
                    CFG_SEED:     lfsr       = (i_cfg_data == 0) ? 32'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                due_tags.push_back(schedule_packet(i_in_item));
            end
        end
        due_cnt <= due_tags.size();
    end

endmodule

@@ bench/testbench.sv @@
// Testbench top: drives packet items and register writes into the scheduler and gives the verdict.
`timescale 1ns / 100ps
module testbench;
    import mprs_pkg::*;

    // cycles with no handshake on any channel before the run is called hung;
    // the slowest item is a rebuild with two random slots plus a slot draw
    // that runs out
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;

    // receiver behavior
    localparam int RX_OPEN   = 0;
    localparam int RX_CHOPPY = 1;
    localparam int RX_CHOKED = 2;

    // packet kinds made by the random generator
    localparam int PK_NOISE       = 0;
    localparam int PK_WRONG_DEST  = 1;
    localparam int PK_WRONG_PROTO = 2;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_item   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    int fail_cnt;
    int due_cnt;

    // stimulus side bookkeeping
    logic [31:0] group_addr  = RST_GROUP;
    int          burst_left  = 0;
    int          quiet       = 0;
    int          rx_mode     = RX_OPEN;
    int          rx_left     = 0;

    // default rates that hit every rebuild branch: both ends, next to the
    // ends, both edges of the invalid block, an invalid default, mid range
    int corner_rates [11] = '{0, 15, 1, 14, 7, 8, 11, 12, 13, 3, 6};

    multicast_probe_rate_scheduler u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rate_sched_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (fail_cnt),
        .o_pending   (due_cnt)
    );

    always #4 clk = ~clk;

    // Receiver: switches between open, choppy and choked stretches of random
    // length, so back-pressure holds both the output register and the emit state.
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_CHOKED);
            rx_left = $urandom_range(50, 300);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
            default:   out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Watchdog: any handshake clears it.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic t_in_item packet_of(input logic [7:0] proto, input logic [31:0] dest,
                                           input logic fb, input t_rate def);
        t_in_item p;
        p.protocol         = proto;
        p.dest_address     = dest;
        p.feedback_arrived = fb;
        p.default_rate     = def;
        return p;
    endfunction

    // Mostly packets for the current group, with an occasional rebuild;
    // the rest are near misses and plain noise.
    function automatic t_in_item make_packet();
        t_in_item p;
        int       kind;
        kind = $urandom_range(0, 15);
        p = packet_of(UDP_PROTO, group_addr, $urandom_range(0, 7) == 0,
                      t_rate'($urandom_range(0, 15)));
        case (kind)
            PK_NOISE: begin
                p.protocol         = 8'($urandom);
                p.dest_address     = $urandom;
                p.feedback_arrived = 1'($urandom);
            end
            PK_WRONG_DEST: begin
                p.dest_address = group_addr ^ (32'd1 << $urandom_range(0, 31));
            end
            PK_WRONG_PROTO: begin
                p.protocol = 8'($urandom_range(0, 254));
                if (p.protocol >= UDP_PROTO) begin
                    p.protocol = p.protocol + 8'd1;
                end
            end
            default: ;
        endcase
        return p;
    endfunction

    // Called and returns just after a falling edge. The sender runs in
    // bursts; between bursts valid drops for a random gap.
    task automatic send(input t_in_item it);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Hold the sender until every result item is back, then let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (due_cnt != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // Registers change only with the block idle.
    task automatic apply_settings(input logic [31:0] group, input logic [7:0] main_b,
                                  input logic [7:0] probe_b, input logic [7:0] interval,
                                  input logic [31:0] seed);
        drain();
        write_reg(CFG_GROUP, group);
        write_reg(CFG_MAIN, {24'd0, main_b});
        write_reg(CFG_PROBE, {24'd0, probe_b});
        write_reg(CFG_INTERVAL, {24'd0, interval});
        write_reg(CFG_SEED, seed);
        cfg_valid <= 1'b0;
        group_addr = group;
    endtask

    initial begin
        int n_items;
        int pause_at;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on reset settings.
        send(packet_of(8'h00, 32'h0000_0000, 1'b0, 4'd0));
        send(packet_of(8'hFF, 32'hFFFF_FFFF, 1'b1, 4'd15));
        send(packet_of(UDP_PROTO, RST_GROUP ^ 32'd1, 1'b1, 4'd3));
        send(packet_of(UDP_PROTO - 8'd1, RST_GROUP, 1'b1, 4'd3));
        // matched before any rebuild: all budgets still empty
        send(packet_of(UDP_PROTO, RST_GROUP, 1'b0, 4'd5));
        foreach (corner_rates[i]) begin
            send(packet_of(UDP_PROTO, RST_GROUP, 1'b1, t_rate'(corner_rates[i])));
        end
        repeat (4) send(packet_of(UDP_PROTO, RST_GROUP, 1'b0, 4'd9));

        // Random phases, one register setting each: widest budgets and
        // interval, then empty budgets with a zero seed, then a zero interval,
        // the reset values, small random values, and a last fast setting
        // with a zero interval and tiny budgets.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_settings($urandom, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);
                1: apply_settings(32'h0000_0000, 8'd0, 8'd0, 8'd1, 32'd0);
                2: apply_settings(32'hFFFF_FFFF, 8'd1, 8'd1, 8'd0, $urandom);
                3: apply_settings(RST_GROUP, RST_MAIN, RST_PROBE, RST_INTERVAL, $urandom);
                4: apply_settings($urandom, 8'($urandom_range(0, 5)),
                                  8'($urandom_range(0, 5)),
                                  8'($urandom_range(1, 30)), $urandom);
                default: apply_settings($urandom, 8'd2, 8'd3, 8'd0, RST_SEED);
            endcase
            n_items  = $urandom_range(120, 200);
            pause_at = $urandom_range(1, 100);
            for (int k = 0; k < n_items; k++) begin
                // sender waits out every result item, once per phase for sure
                if (k == pause_at || $urandom_range(0, 63) == 0) begin
                    drain();
                end
                send(make_packet());
            end
        end

        drain();
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
